// ===== design/lrast_pkg.sv =====
// Package with the shared widths, types and control structs of the line rasterizer.
`default_nettype none

package lrast_pkg;

    // Width of the coordinate fields on the ports.
    localparam int FIELD_W    = 6;
    // Coordinate bits used by the stepper; port bits above this are ignored.
    localparam int COORD_BITS = 6;
    localparam int COLOR_W    = 32;

    typedef logic [FIELD_W-1:0]    t_field;
    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [COORD_BITS:0]   t_err;
    typedef logic [COLOR_W-1:0]    t_color;

    // Command payload as seen by the datapath.
    typedef struct packed {
        t_field start_x;
        t_field start_y;
        t_field end_x;
        t_field end_y;
        t_color line_color;
    } t_cmd_data;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic setup;
        logic step;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic major_zero;
        logic last_step;
        logic out_free;
    } t_ctl_sts;

endpackage

`default_nettype wire

// ===== design/lrast_if.sv =====
// Handshake interfaces for the line command channel and the pixel channel.
`default_nettype none

interface lrast_cmd_if import lrast_pkg::*; ();
    logic   valid;
    logic   ready;
    t_field start_x;
    t_field start_y;
    t_field end_x;
    t_field end_y;
    t_color line_color;

    modport source (output valid, start_x, start_y, end_x, end_y, line_color, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, line_color, output ready);
endinterface

interface lrast_pix_if import lrast_pkg::*; ();
    logic   valid;
    logic   ready;
    t_field pixel_x;
    t_field pixel_y;
    t_color pixel_color;
    logic   last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

`default_nettype wire

// ===== design/lrast_ctrl.sv =====
// Controller state machine that sequences command load, setup and pixel stepping.
`default_nettype none

module lrast_ctrl import lrast_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cmd_valid,
    output logic          o_cmd_ready,
    input  wire t_ctl_sts i_sts,
    output t_ctl_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SETUP = 3'b010,
        S_RUN   = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // A new command is taken only while the stepper is idle.
    assign o_cmd_ready = (r_state == S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        o_cmd.load  = 1'b0;
        o_cmd.setup = 1'b0;
        o_cmd.step  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = i_sts.major_zero ? S_IDLE : S_RUN;
            end
            S_RUN: begin
                // Step only when the pixel register can take a new pixel.
                if (i_sts.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.last_step) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== design/lrast_dp.sv =====
// Datapath with the command registers, the Bresenham stepper and the pixel output register.
`default_nettype none

module lrast_dp import lrast_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cmd_data i_cmd_data,
    input  wire t_ctl_cmd  i_cmd,
    output t_ctl_sts       o_sts,
    input  wire logic      i_pix_ready,
    output logic           o_pix_valid,
    output t_field         o_pixel_x,
    output t_field         o_pixel_y,
    output t_color         o_pixel_color,
    output logic           o_last_pixel
);

    // Latched command.
    t_coord r_sx, r_sy, r_ex, r_ey;
    t_color r_color;

    // Stepper state.
    t_coord r_px, r_py;
    t_err   r_err;
    t_coord r_major, r_minor, r_cnt;
    logic   r_xmaj, r_xneg, r_yneg;

    // Pixel output register. It keeps its own copy of the color, because the
    // next command may be latched while the last pixel is still waiting.
    logic   r_pv;
    t_coord r_pix_x, r_pix_y;
    t_color r_pix_color;
    logic   r_pix_last;

    // Setup values derived from the latched endpoints.
    logic   s_xneg, s_yneg, s_xmaj;
    t_coord s_adx, s_ady, s_major, s_minor, s_px0, s_py0;
    logic   s_sxneg, s_syneg;

    always_comb begin
        s_xneg = (r_ex < r_sx);
        s_yneg = (r_ey < r_sy);
        s_adx  = s_xneg ? (r_sx - r_ex) : (r_ex - r_sx);
        s_ady  = s_yneg ? (r_sy - r_ey) : (r_ey - r_sy);
        priority if (s_ady == '0) begin
            // Horizontal line: start one before the smaller x and count up.
            s_xmaj  = 1'b1;
            s_major = s_adx;
            s_minor = '0;
            s_sxneg = 1'b0;
            s_syneg = 1'b0;
            s_px0   = (s_xneg ? r_ex : r_sx) - COORD_BITS'(1);
            s_py0   = r_sy;
        end else if (s_adx == '0) begin
            // Vertical line: start one before the smaller y and count up.
            s_xmaj  = 1'b0;
            s_major = s_ady;
            s_minor = '0;
            s_sxneg = 1'b0;
            s_syneg = 1'b0;
            s_px0   = r_sx;
            s_py0   = (s_yneg ? r_ey : r_sy) - COORD_BITS'(1);
        end else begin
            // General line: step from the start point along the major axis.
            s_xmaj  = (s_adx >= s_ady);
            s_major = s_xmaj ? s_adx : s_ady;
            s_minor = s_xmaj ? s_ady : s_adx;
            s_sxneg = s_xneg;
            s_syneg = s_yneg;
            s_px0   = r_sx;
            s_py0   = r_sy;
        end
    end

    // One Bresenham step: add the minor span, take a minor step on overflow.
    t_err   st_sum, st_err;
    logic   st_minor;
    t_coord st_xinc, st_yinc, st_px, st_py;

    always_comb begin
        st_sum   = r_err + {1'b0, r_minor};
        st_minor = (st_sum >= {1'b0, r_major});
        st_err   = st_minor ? (st_sum - {1'b0, r_major}) : st_sum;
        st_xinc  = r_xneg ? (r_px - COORD_BITS'(1)) : (r_px + COORD_BITS'(1));
        st_yinc  = r_yneg ? (r_py - COORD_BITS'(1)) : (r_py + COORD_BITS'(1));
        st_px    = (r_xmaj || st_minor) ? st_xinc : r_px;
        st_py    = (!r_xmaj || st_minor) ? st_yinc : r_py;
    end

    // Status toward the controller.
    assign o_sts.major_zero = (s_major == '0);
    assign o_sts.last_step  = (r_cnt == COORD_BITS'(1));
    assign o_sts.out_free   = !r_pv || i_pix_ready;

    // Command latch.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sx    <= i_cmd_data.start_x[COORD_BITS-1:0];
            r_sy    <= i_cmd_data.start_y[COORD_BITS-1:0];
            r_ex    <= i_cmd_data.end_x[COORD_BITS-1:0];
            r_ey    <= i_cmd_data.end_y[COORD_BITS-1:0];
            r_color <= i_cmd_data.line_color;
        end
    end

    // Stepper registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_px    <= s_px0;
            r_py    <= s_py0;
            r_err   <= {2'b00, s_major[COORD_BITS-1:1]};
            r_major <= s_major;
            r_minor <= s_minor;
            r_cnt   <= s_major;
            r_xmaj  <= s_xmaj;
            r_xneg  <= s_sxneg;
            r_yneg  <= s_syneg;
        end else if (i_cmd.step) begin
            r_px  <= st_px;
            r_py  <= st_py;
            r_err <= st_err;
            r_cnt <= r_cnt - COORD_BITS'(1);
        end
    end

    // Pixel register: filled by a step, emptied by a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_cmd.step) begin
            r_pv <= 1'b1;
        end else if (i_pix_ready) begin
            r_pv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_pix_x     <= st_px;
            r_pix_y     <= st_py;
            r_pix_color <= r_color;
            r_pix_last  <= (r_cnt == COORD_BITS'(1));
        end
    end

    assign o_pix_valid   = r_pv;
    assign o_pixel_x     = FIELD_W'(r_pix_x);
    assign o_pixel_y     = FIELD_W'(r_pix_y);
    assign o_pixel_color = r_pix_color;
    assign o_last_pixel  = r_pix_last;

endmodule

`default_nettype wire

// ===== design/line_rasterizer.sv =====
// Top level of the line rasterizer: joins the controller and the datapath to the channels.
//
//   Channel   Direction  Transfer  Payload
//   i_cmd     in         one line  start_x, start_y, end_x, end_y, line_color
//   o_pix     out        one pixel pixel_x, pixel_y, pixel_color, last_pixel
//
// A command is latched, then set up, then stepped at one pixel per cycle while the pixel
// channel does not stall, for max(|dx|, |dy|) pixels, at most 63, by the Bresenham stepper.
// The command channel is ready only while the stepper is idle.
// A stall on the pixel channel holds the stepper; the last pixel may wait in the
// output register while the next command is already taken.
// Reset clears the state machine and the pixel valid flag.
`default_nettype none

module line_rasterizer import lrast_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lrast_cmd_if.sink  i_cmd,
    lrast_pix_if.source o_pix
);

    t_ctl_cmd  w_cmd;
    t_ctl_sts  w_sts;
    t_cmd_data w_cmd_data;
    logic      w_cmd_ready;

    assign i_cmd.ready = w_cmd_ready;

    // Command payload into the datapath.
    assign w_cmd_data.start_x    = i_cmd.start_x;
    assign w_cmd_data.start_y    = i_cmd.start_y;
    assign w_cmd_data.end_x      = i_cmd.end_x;
    assign w_cmd_data.end_y      = i_cmd.end_y;
    assign w_cmd_data.line_color = i_cmd.line_color;

    lrast_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .o_cmd_ready (w_cmd_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    lrast_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_data    (w_cmd_data),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_pix_ready   (o_pix.ready),
        .o_pix_valid   (o_pix.valid),
        .o_pixel_x     (o_pix.pixel_x),
        .o_pixel_y     (o_pix.pixel_y),
        .o_pixel_color (o_pix.pixel_color),
        .o_last_pixel  (o_pix.last_pixel)
    );

endmodule

`default_nettype wire

// ===== bench/tb_line_rasterizer.sv =====
// Self-checking testbench for the line rasterizer: directed and random line commands.
`timescale 1ns / 100ps

module tb_line_rasterizer;
    import lrast_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int RST_CYCLES  = 7;
    localparam int IDLE_PCT    = 21;
    localparam int N_LINES     = 285;
    localparam int CALM_FIRST  = 140;
    localparam int CALM_LAST   = 200;
    localparam int MAX_COORD   = (1 << COORD_BITS) - 1;
    localparam int TAIL_CYCLES = 80;
    localparam int DRAIN_LIMIT = 20_000;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int N_DIRECTED  = 25;

    // One pixel as seen on the output channel.
    typedef struct packed {
        t_field x;
        t_field y;
        t_color color;
        logic   last;
    } t_pixel;

    typedef t_pixel t_pixel_q[$];

    // Directed row: a command, and optionally the pixel list typed in by hand.
    typedef struct packed {
        t_cmd_data cmd;
        bit        typed;
        bit        one_pixel;
        t_field    px;
        t_field    py;
    } t_line_row;

    localparam t_line_row LINE_ROWS [N_DIRECTED] = '{
        // One-pixel lines and degenerate commands, expectations typed in.
        '{'{6'd0,  6'd0,  6'd1,  6'd0,  32'hFFFF_FFFF}, 1'b1, 1'b1, 6'd0,  6'd0},
        '{'{6'd1,  6'd0,  6'd0,  6'd0,  32'h0000_0000}, 1'b1, 1'b1, 6'd0,  6'd0},
        '{'{6'd0,  6'd0,  6'd0,  6'd1,  32'hA5A5_A5A5}, 1'b1, 1'b1, 6'd0,  6'd0},
        '{'{6'd0,  6'd1,  6'd0,  6'd0,  32'h5A5A_5A5A}, 1'b1, 1'b1, 6'd0,  6'd0},
        '{'{6'd0,  6'd0,  6'd1,  6'd1,  32'h1234_5678}, 1'b1, 1'b1, 6'd1,  6'd1},
        '{'{6'd63, 6'd63, 6'd62, 6'd62, 32'h8000_0001}, 1'b1, 1'b1, 6'd62, 6'd62},
        '{'{6'd5,  6'd5,  6'd5,  6'd5,  32'hFFFF_FFFF}, 1'b1, 1'b0, 6'd0,  6'd0},
        '{'{6'd63, 6'd63, 6'd63, 6'd63, 32'h0000_0000}, 1'b1, 1'b0, 6'd0,  6'd0},
        // Full-span axis lines in both directions.
        '{'{6'd0,  6'd0,  6'd63, 6'd0,  32'h0000_0000}, 1'b0, 1'b0, 6'd0,  6'd0},
        '{'{6'd63, 6'd63, 6'd0,  6'd63, 32'hFFFF_FFFF}, 1'b0, 1'b0, 6'd0,  6'd0},
        '{'{6'd0,  6'd0,  6'd0,  6'd63, 32'hA5A5_A5A5}, 1'b0, 1'b0, 6'd0,  6'd0},
        '{'{6'd63, 6'd63, 6'd63, 6'd0,  32'h5A5A_5A5A}, 1'b0, 1'b0, 6'd0,  6'd0},
        // Full-span diagonals in all four directions.
        '{'{6'd0,  6'd0,  6'd63, 6'd63, 32'h0F0F_0F0F}, 1'b0, 1'b0, 6'd0,  6'd0},
        '{'{6'd63, 6'd0,  6'd0,  6'd63, 32'hF0F0_F0F0}, 1'b0, 1'b0, 6'd0,  6'd0},
        '{'{6'd0,  6'd63, 6'd63, 6'd0,  32'h3333_CCCC}, 1'b0, 1'b0, 6'd0,  6'd0},
        '{'{6'd63, 6'd63, 6'd0,  6'd0,  32'hCCCC_3333}, 1'b0, 1'b0, 6'd0,  6'd0},
        // Nearly flat and nearly steep lines, then lines in four of the octants.
        '{'{6'd0,  6'd0,  6'd63, 6'd1,  32'h0123_4567}, 1'b0, 1'b0, 6'd0,  6'd0},
        '{'{6'd63, 6'd0,  6'd62, 6'd63, 32'h89AB_CDEF}, 1'b0, 1'b0, 6'd0,  6'd0},
        '{'{6'd10, 6'd20, 6'd30, 6'd27, 32'hDEAD_BEEF}, 1'b0, 1'b0, 6'd0,  6'd0},
        '{'{6'd30, 6'd27, 6'd10, 6'd20, 32'hCAFE_F00D}, 1'b0, 1'b0, 6'd0,  6'd0},
        '{'{6'd20, 6'd10, 6'd27, 6'd30, 32'h0BAD_F00D}, 1'b0, 1'b0, 6'd0,  6'd0},
        '{'{6'd27, 6'd30, 6'd20, 6'd10, 32'h7FFF_FFFF}, 1'b0, 1'b0, 6'd0,  6'd0},
        // Short lines where the error term ties with the major span.
        '{'{6'd0,  6'd0,  6'd2,  6'd1,  32'h0000_0001}, 1'b0, 1'b0, 6'd0,  6'd0},
        '{'{6'd0,  6'd0,  6'd1,  6'd2,  32'h8000_0000}, 1'b0, 1'b0, 6'd0,  6'd0},
        '{'{6'd40, 6'd5,  6'd41, 6'd60, 32'h5555_AAAA}, 1'b0, 1'b0, 6'd0,  6'd0}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic sink_ready = 1'b0;
    bit   calm = 1'b0;
    int   n_bad_pixels = 0;
    int   n_cycles = 0;
    t_pixel pending_pixels[$];

    lrast_cmd_if cmd_if ();
    lrast_pix_if pix_if ();

    line_rasterizer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_pix   (pix_if)
    );

    assign pix_if.ready = sink_ready;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Pixel receiver: stalls at random, except during the calm stretch.
    always @(negedge i_clk) begin
        sink_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Hard stop if the run hangs.
    always @(posedge i_clk) begin
        n_cycles = n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Build one pixel; the caller marks the last one of a line.
    function automatic t_pixel dot(input int x, input int y, input t_color col);
        t_pixel p;
        p.x     = t_field'(x);
        p.y     = t_field'(y);
        p.color = col;
        p.last  = 1'b0;
        return p;
    endfunction

    // Pixels that one line command draws, in output order.
    function automatic t_pixel_q trace_line(input t_cmd_data c);
        t_pixel_q pix_q;
        int x0, y0, x1, y1, dx, dy, adx, ady, stx, sty, px, py, err, i;
        x0  = int'(t_coord'(c.start_x));
        y0  = int'(t_coord'(c.start_y));
        x1  = int'(t_coord'(c.end_x));
        y1  = int'(t_coord'(c.end_y));
        dx  = x1 - x0;
        dy  = y1 - y0;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        stx = (dx < 0) ? -1 : 1;
        sty = (dy < 0) ? -1 : 1;
        px  = x0;
        py  = y0;
        if (dy == 0) begin
            // Horizontal: from the smaller x, larger x left out.
            for (i = 0; i < adx; i++)
                pix_q.push_back(dot(((dx < 0) ? x1 : x0) + i, y0, c.line_color));
        end else if (dx == 0) begin
            // Vertical: from the smaller y, larger y left out.
            for (i = 0; i < ady; i++)
                pix_q.push_back(dot(x0, ((dy < 0) ? y1 : y0) + i, c.line_color));
        end else if (adx >= ady) begin
            // Shallow: x is the major axis.
            err = adx >> 1;
            for (i = 0; i < adx; i++) begin
                err += ady;
                if (err >= adx) begin
                    err -= adx;
                    py  += sty;
                end
                px += stx;
                pix_q.push_back(dot(px, py, c.line_color));
            end
        end else begin
            // Steep: y is the major axis.
            err = ady >> 1;
            for (i = 0; i < ady; i++) begin
                err += adx;
                if (err >= ady) begin
                    err -= ady;
                    px  += stx;
                end
                py += sty;
                pix_q.push_back(dot(px, py, c.line_color));
            end
        end
        if (pix_q.size() > 0)
            pix_q[pix_q.size() - 1].last = 1'b1;
        return pix_q;
    endfunction

    // A coordinate a few steps away from base, clipped to the tile.
    function automatic t_field near(input t_field base);
        int v;
        v = int'(base) + int'($urandom_range(8)) - 4;
        if (v < 0)
            v = 0;
        if (v > MAX_COORD)
            v = MAX_COORD;
        return t_field'(v);
    endfunction

    // Random line command, biased toward axis lines, short lines and single-point commands.
    function automatic t_cmd_data random_line();
        t_cmd_data c;
        int kind;
        kind        = $urandom_range(99);
        c.start_x   = t_field'($urandom_range(MAX_COORD));
        c.start_y   = t_field'($urandom_range(MAX_COORD));
        c.end_x     = t_field'($urandom_range(MAX_COORD));
        c.end_y     = t_field'($urandom_range(MAX_COORD));
        if (kind < 12) begin
            c.end_y = c.start_y;
        end else if (kind < 24) begin
            c.end_x = c.start_x;
        end else if (kind < 29) begin
            c.end_x = c.start_x;
            c.end_y = c.start_y;
        end else if (kind < 55) begin
            c.end_x = near(c.start_x);
            c.end_y = near(c.start_y);
        end
        case ($urandom_range(9))
            0:       c.line_color = '0;
            1:       c.line_color = '1;
            default: c.line_color = t_color'($urandom);
        endcase
        return c;
    endfunction

    // Offer one command, with random gaps first; expectations are queued
    // at the edge where the transfer happens. Called and returns at a falling edge.
    task automatic drive_line(input t_cmd_data c, input t_pixel_q want_q);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            cmd_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.start_x    <= c.start_x;
        cmd_if.start_y    <= c.start_y;
        cmd_if.end_x      <= c.end_x;
        cmd_if.end_y      <= c.end_y;
        cmd_if.line_color <= c.line_color;
        do
            @(posedge i_clk);
        while (!cmd_if.ready);
        foreach (want_q[i])
            pending_pixels.push_back(want_q[i]);
        @(negedge i_clk);
    endtask

    // Pixel checker: every transfer is compared with the oldest expectation.
    always @(posedge i_clk) begin : pixel_check
        t_pixel want;
        if (i_rst_n && pix_if.valid && pix_if.ready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel at x=%0d y=%0d", pix_if.pixel_x, pix_if.pixel_y);
                n_bad_pixels++;
            end else begin
                want = pending_pixels.pop_front();
                if (pix_if.pixel_x !== want.x) begin
                    $error("pixel_x: expected %0d, actual %0d", want.x, pix_if.pixel_x);
                    n_bad_pixels++;
                end
                if (pix_if.pixel_y !== want.y) begin
                    $error("pixel_y: expected %0d, actual %0d", want.y, pix_if.pixel_y);
                    n_bad_pixels++;
                end
                if (pix_if.pixel_color !== want.color) begin
                    $error("pixel_color: expected %08h, actual %08h",
                           want.color, pix_if.pixel_color);
                    n_bad_pixels++;
                end
                if (pix_if.last_pixel !== want.last) begin
                    $error("last_pixel: expected %0b, actual %0b", want.last,
                           pix_if.last_pixel);
                    n_bad_pixels++;
                end
            end
        end
    end

    initial begin
        t_pixel_q  want_q;
        t_cmd_data c;
        int        n_lines;
        int        n_wait;

        cmd_if.valid      = 1'b0;
        cmd_if.start_x    = '0;
        cmd_if.start_y    = '0;
        cmd_if.end_x      = '0;
        cmd_if.end_y      = '0;
        cmd_if.line_color = '0;

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: hand-typed pixels where given, else the predictor.
        for (int r = 0; r < N_DIRECTED; r++) begin
            want_q.delete();
            if (LINE_ROWS[r].typed) begin
                if (LINE_ROWS[r].one_pixel) begin
                    want_q.push_back(dot(int'(LINE_ROWS[r].px), int'(LINE_ROWS[r].py),
                                         LINE_ROWS[r].cmd.line_color));
                    want_q[0].last = 1'b1;
                end
            end else begin
                want_q = trace_line(LINE_ROWS[r].cmd);
            end
            drive_line(LINE_ROWS[r].cmd, want_q);
        end

        // Random commands; degenerate ones are not counted.
        n_lines = 0;
        while (n_lines < N_LINES) begin
            calm = (n_lines >= CALM_FIRST) && (n_lines < CALM_LAST);
            c = random_line();
            drive_line(c, trace_line(c));
            if (c.start_x != c.end_x || c.start_y != c.end_y)
                n_lines++;
        end
        calm = 1'b0;
        cmd_if.valid <= 1'b0;

        // Drain the pixel channel, then watch for stray transfers.
        n_wait = 0;
        while (pending_pixels.size() != 0 && n_wait < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n_wait++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_pixels.size() != 0) begin
            $error("%0d expected pixels never arrived", pending_pixels.size());
            n_bad_pixels++;
        end

        if (n_bad_pixels == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/lrast_pkg.sv
design/lrast_if.sv
design/lrast_ctrl.sv
design/lrast_dp.sv
design/line_rasterizer.sv
bench/tb_line_rasterizer.sv
